// ----- hw/rtl/sorted_array_priority_queue_defines.svh -----
// assertion macros for the sorted array priority queue
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// property checked on every clock edge outside reset
`define SAPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sapq assertion failed");

// condition in one cycle implies a condition in the next
`define SAPQ_ASSERT_NEXT(lbl, cond, nxt) \
    `SAPQ_ASSERT(lbl, (cond) |=> (nxt))

`endif

// ----- hw/rtl/sapq_pkg.sv -----
// package of types and constants for the sorted array priority queue
`default_nettype none

package sapq_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               command;
        logic signed [31:0] entry_key;
        logic        [7:0]  entry_value;
    } t_in;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] removed_key;
        logic        [7:0]  removed_value;
        logic        [6:0]  entry_count;
        logic               is_empty;
        logic signed [31:0] min_key;
        logic        [7:0]  min_value;
    } t_out;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/sapq_ctrl.sv -----
// controller state machine for the sorted array priority queue
`default_nettype none
`include "sorted_array_priority_queue_defines.svh"

module sapq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output sapq_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   exec;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign exec        = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = accept;
    assign o_cmd.exec  = exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SAPQ_ASSERT_NEXT(a_exec_gives_result, exec, r_out_valid)
    `SAPQ_ASSERT_NEXT(a_accept_starts_exec, accept, r_state == ST_EXEC)
    `SAPQ_ASSERT_NEXT(a_one_item_at_a_time, accept, !accept)

endmodule

`default_nettype wire

// ----- hw/rtl/sapq_datapath.sv -----
// sorted entry cells, count and result register of the priority queue
`default_nettype none
`include "sorted_array_priority_queue_defines.svh"

module sapq_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sapq_pkg::t_dp_cmd i_cmd,
    input  wire sapq_pkg::t_in     i_in_data,
    output sapq_pkg::t_out         o_out_data
);

    localparam int DEPTH = sapq_pkg::DEPTH;
    localparam int CNT_W = sapq_pkg::CNT_W;

    logic signed [31:0]      r_key [DEPTH];
    logic        [7:0]       r_val [DEPTH];
    logic signed [31:0]      n_key [DEPTH];
    logic        [7:0]       n_val [DEPTH];
    logic        [CNT_W-1:0] r_count;
    logic        [CNT_W-1:0] n_count;
    sapq_pkg::t_in           r_op;
    sapq_pkg::t_out          r_out;
    sapq_pkg::t_out          n_out;
    logic        [DEPTH-1:0] le;
    logic                    full;
    logic                    empty;
    logic                    do_ins;
    logic                    do_rem;

    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);
    assign do_ins = i_cmd.exec && (r_op.command == sapq_pkg::CMD_INSERT) && !full;
    assign do_rem = i_cmd.exec && (r_op.command == sapq_pkg::CMD_REMOVE) && !empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic               lo_le;
        logic signed [31:0] lo_key;
        logic        [7:0]  lo_val;
        logic signed [31:0] hi_key;
        logic        [7:0]  hi_val;

        assign le[g] = (CNT_W'(g) < r_count) && (r_key[g] <= r_op.entry_key);

        if (g == 0) begin : g_first
            assign lo_le  = 1'b1;
            assign lo_key = r_key[g];
            assign lo_val = r_val[g];
        end else begin : g_mid
            assign lo_le  = le[g-1];
            assign lo_key = r_key[g-1];
            assign lo_val = r_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign hi_key = r_key[g];
            assign hi_val = r_val[g];
        end else begin : g_body
            assign hi_key = r_key[g+1];
            assign hi_val = r_val[g+1];
        end

        always_comb begin
            n_key[g] = r_key[g];
            n_val[g] = r_val[g];
            if (do_ins) begin
                if (le[g]) begin
                    n_key[g] = r_key[g];
                    n_val[g] = r_val[g];
                end else if (lo_le) begin
                    n_key[g] = r_op.entry_key;
                    n_val[g] = r_op.entry_value;
                end else begin
                    n_key[g] = lo_key;
                    n_val[g] = lo_val;
                end
            end else if (do_rem) begin
                n_key[g] = hi_key;
                n_val[g] = hi_val;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out               = '0;
        n_out.status        = sapq_pkg::STATUS_DONE;
        if ((r_op.command == sapq_pkg::CMD_INSERT) && full) begin
            n_out.status = sapq_pkg::STATUS_FULL;
        end else if ((r_op.command == sapq_pkg::CMD_REMOVE) && empty) begin
            n_out.status = sapq_pkg::STATUS_EMPTY;
        end
        if (do_rem) begin
            n_out.removed_key   = r_key[0];
            n_out.removed_value = r_val[0];
        end
        n_out.entry_count = 7'(n_count);
        n_out.is_empty    = (n_count == '0);
        if (n_count != '0) begin
            n_out.min_key   = n_key[0];
            n_out.min_value = n_val[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
        if (do_ins || do_rem) begin
            r_key <= n_key;
            r_val <= n_val;
        end
    end

    assign o_out_data = r_out;

    `SAPQ_ASSERT(a_count_bounded, r_count <= CNT_W'(DEPTH))
    `SAPQ_ASSERT(a_front_sorted, (r_count >= CNT_W'(2)) |-> (r_key[0] <= r_key[1]))
    `SAPQ_ASSERT_NEXT(a_insert_counts_up, do_ins, r_count == CNT_W'($past(r_count) + 1'b1))

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_array_priority_queue.sv -----
// an accepted item is loaded into the operand register and run in the execute state; its result is
// then held in the output register; no new item is taken until the controller is idle again
// execution waits while a previous result is still stalled in the output register
// reset clears the entry count and the handshake state; stored entries are left as they are
// top level of the sorted array priority queue
`default_nettype none

module sorted_array_priority_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire sapq_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output sapq_pkg::t_out      o_out_data
);

    sapq_pkg::t_dp_cmd cmd;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    sapq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
